@@ src/mcg_pkg.sv @@
package mcg_pkg;

   // default click table depth and channel count
   localparam int CLICK_DEPTH_DEF = 4096;
   localparam int CHANNELS        = 2;

   // field widths
   localparam int FRAME_W  = 48;
   localparam int SAMPLE_W = 16;
   localparam int TADDR_W  = 12;
   localparam int LEN_W    = 13;
   localparam int FPB_W    = 32;
   localparam int BPB_W    = 8;

   // beat index and divider sizing
   localparam int NUM_W    = FRAME_W + 8;
   localparam int CNT_W    = $clog2(NUM_W);

   // stream word widths
   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   // configuration register indexes
   localparam logic [1:0] CSR_FPB    = 2'd0;
   localparam logic [1:0] CSR_BPB    = 2'd1;
   localparam logic [1:0] CSR_ALEN   = 2'd2;
   localparam logic [1:0] CSR_NLEN   = 2'd3;
   localparam logic [BPB_W-1:0] BPB_RESET = 8'd4;

   typedef enum logic [1:0] {
      OP_FRAME     = 2'd0,
      OP_WR_ACCENT = 2'd1,
      OP_WR_NORMAL = 2'd2,
      OP_RESET     = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MISC,
      ST_START,
      ST_DIV,
      ST_BEAT,
      ST_CHECK,
      ST_MOD,
      ST_ACCENT,
      ST_PLAY,
      ST_DONE
   } state_type;

endpackage

@@ src/mcg_ram.sv @@
module mcg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/metronome_click_generator.sv @@
// Metronome click generator.
// req_ channel: one word per request; tuser carries the opcode (process frame,
// write accent table, write normal table, reset playback). A frame word carries
// the signed frame index and the left/right samples to mix the click into.
// rsp_ channel: exactly one word per request: both mixed samples, the click
// sample, and tuser flags for a new beat and an accented beat.
// csr_ port: frames per beat (Q24.8), beats per bar and the two click lengths;
// the user must write them only while idle, the block does not enforce this.
// Timing: the beat index comes from one shared restoring divider, one quotient
// bit per cycle over all 56 dividend bits; the same divider then takes the beat
// index modulo beats per bar, again over 56 bits, but only on a frame that starts
// a beat. A frame with frames per beat zero skips the divider and goes straight
// to playback; table writes and playback reset pass through the misc state.
// Ready returns as the registered result appears on rsp_; one request at a
// time. While rsp_tready is low the output register holds its word; the block
// can still take one request, whose finished result then waits until that
// register frees, and no further request is taken meanwhile.
// Reset clears the settings to their defaults and stops playback; the click
// tables are not cleared and must be loaded before use.
module metronome_click_generator #(
   parameter int CLICK_DEPTH = mcg_pkg::CLICK_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: frame_index[47:0], in_left[63:48], in_right[79:64],
   //        table_address[91:80], table_value[107:92], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mcg_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: opcode[1:0]
   input  logic [mcg_pkg::REQ_USER_W-1:0]  req_tuser,
   // tdata: mixed_left[15:0], mixed_right[31:16], click_sample[47:32]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mcg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: new_beat[0], accented_beat[1]
   output logic [mcg_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_addr,
   input  logic [mcg_pkg::FPB_W-1:0]       csr_wdata
);

   localparam int AddrW = $clog2(CLICK_DEPTH);
   localparam int NumW  = mcg_pkg::NUM_W;
   localparam int SW    = mcg_pkg::SAMPLE_W;
   localparam int LW    = mcg_pkg::LEN_W;
   localparam int FW    = mcg_pkg::FPB_W;
   localparam int CW    = mcg_pkg::CNT_W;

   // saturate a 17-bit sum to 16 bits
   function automatic logic [15:0] sat16(input logic [16:0] s);
      logic [15:0] r;
      if (s[16] != s[15]) begin
         r = s[16] ? 16'h8000 : 16'h7FFF;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

   // sequencer
   mcg_pkg::state_type state_ff, state_in;

   // captured request
   mcg_pkg::opcode_type op_ff, op_in;
   logic [mcg_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [SW-1:0] left_ff, left_in, right_ff, right_in, tval_ff, tval_in;
   logic [mcg_pkg::TADDR_W-1:0] taddr_ff, taddr_in;

   // settings
   logic [FW-1:0] fpb_ff, fpb_in;
   logic [mcg_pkg::BPB_W-1:0] bpb_ff, bpb_in;
   logic [LW-1:0] alen_ff, alen_in, nlen_ff, nlen_in;

   // playback state
   logic [NumW-1:0] last_beat_ff, last_beat_in;
   logic beat_seen_ff, beat_seen_in, playing_ff, playing_in, play_acc_ff, play_acc_in;
   logic [LW-1:0] pos_ff, pos_in;

   // shared divider
   logic [FW-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [NumW-1:0] dvd_ff, dvd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // per-frame working values
   logic [NumW-1:0] beat_ff, beat_in;
   logic new_beat_ff, new_beat_in, accent_ff, accent_in, hit_ff, hit_in, hit_acc_ff, hit_acc_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [mcg_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [mcg_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // control from the sequencer
   logic accept, div_load_num, div_load_beat, div_step, play_step, out_load, misc_go;

   // datapath helpers
   logic [NumW-1:0] num, num_mag, beat_mag;
   logic [FW:0] part;
   logic [FW+1:0] diff;
   logic ge, is_new, pos_hit, out_free, addr_ok;
   logic [mcg_pkg::BPB_W-1:0] bpb_eff;
   logic [LW-1:0] len_sel, len_c, pos_after;
   logic [AddrW+LW-1:0] pos_wide;
   logic [AddrW+mcg_pkg::TADDR_W-1:0] taddr_wide;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic acc_we, nrm_we;
   logic [SW-1:0] acc_rd, nrm_rd, click;
   logic [16:0] sum_l, sum_r;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcg_pkg::ST_IDLE: begin
            if (accept) begin
               if (mcg_pkg::opcode_type'(req_tuser) != mcg_pkg::OP_FRAME) begin
                  state_in = mcg_pkg::ST_MISC;
               end else if (fpb_ff != '0) begin
                  state_in = mcg_pkg::ST_START;
               end else begin
                  state_in = mcg_pkg::ST_PLAY;
               end
            end
         end
         mcg_pkg::ST_MISC:   state_in = mcg_pkg::ST_DONE;
         mcg_pkg::ST_START:  state_in = mcg_pkg::ST_DIV;
         mcg_pkg::ST_DIV: begin
            if (cnt_ff == '0) state_in = mcg_pkg::ST_BEAT;
         end
         mcg_pkg::ST_BEAT:   state_in = mcg_pkg::ST_CHECK;
         mcg_pkg::ST_CHECK:  state_in = is_new ? mcg_pkg::ST_MOD : mcg_pkg::ST_PLAY;
         mcg_pkg::ST_MOD: begin
            if (cnt_ff == '0) state_in = mcg_pkg::ST_ACCENT;
         end
         mcg_pkg::ST_ACCENT: state_in = mcg_pkg::ST_PLAY;
         mcg_pkg::ST_PLAY:   state_in = mcg_pkg::ST_DONE;
         mcg_pkg::ST_DONE: begin
            if (out_free) state_in = mcg_pkg::ST_IDLE;
         end
         default:            state_in = mcg_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready    = 1'b0;
      div_load_num  = 1'b0;
      div_load_beat = 1'b0;
      div_step      = 1'b0;
      play_step     = 1'b0;
      out_load      = 1'b0;
      misc_go       = 1'b0;
      unique case (state_ff)
         mcg_pkg::ST_IDLE:   req_tready    = 1'b1;
         mcg_pkg::ST_MISC:   misc_go       = 1'b1;
         mcg_pkg::ST_START:  div_load_num  = 1'b1;
         mcg_pkg::ST_DIV:    div_step      = 1'b1;
         mcg_pkg::ST_BEAT:   ;
         mcg_pkg::ST_CHECK:  div_load_beat = is_new;
         mcg_pkg::ST_MOD:    div_step      = 1'b1;
         mcg_pkg::ST_ACCENT: ;
         mcg_pkg::ST_PLAY:   play_step     = 1'b1;
         mcg_pkg::ST_DONE:   out_load      = out_free;
         default:            ;
      endcase
   end

   // divider operands: magnitude of frame*256 over frames per beat, then
   // magnitude of the beat index over beats per bar
   assign num      = {frame_ff, 8'b0};
   assign num_mag  = frame_ff[mcg_pkg::FRAME_W-1] ? -num : num;
   assign beat_mag = beat_ff[NumW-1] ? -beat_ff : beat_ff;
   assign bpb_eff  = (bpb_ff == '0) ? 8'd1 : bpb_ff;

   // one restoring step: shift in the next dividend bit, trial subtract
   assign part = {rem_ff, dvd_ff[NumW-1]};
   assign diff = {1'b0, part} - {2'b0, dsr_ff};
   assign ge   = !diff[FW+1];

   // beat comparison against the last beat
   assign is_new = !beat_seen_ff || (beat_ff != last_beat_ff);

   // playback length, clamped to the table depth; a length above the depth
   // only happens when the depth fits in the length field
   assign len_sel   = play_acc_ff ? alen_ff : nlen_ff;
   assign len_c     = (32'(len_sel) > CLICK_DEPTH) ? LW'(CLICK_DEPTH) : len_sel;
   assign pos_hit   = playing_ff && (pos_ff < len_c);
   assign pos_after = pos_hit ? pos_ff + 1'b1 : pos_ff;

   // table addressing
   assign pos_wide   = {{AddrW{1'b0}}, pos_ff};
   assign rd_addr    = pos_wide[AddrW-1:0];
   assign taddr_wide = {{AddrW{1'b0}}, taddr_ff};
   assign wr_addr    = taddr_wide[AddrW-1:0];
   assign addr_ok    = 32'(taddr_ff) < CLICK_DEPTH;
   assign acc_we     = misc_go && (op_ff == mcg_pkg::OP_WR_ACCENT) && addr_ok;
   assign nrm_we     = misc_go && (op_ff == mcg_pkg::OP_WR_NORMAL) && addr_ok;

   // mix the click into both channels
   assign click = hit_ff ? (hit_acc_ff ? acc_rd : nrm_rd) : '0;
   assign sum_l = {left_ff[SW-1], left_ff} + {click[SW-1], click};
   assign sum_r = {right_ff[SW-1], right_ff} + {click[SW-1], click};

   // datapath next values
   always_comb begin
      op_in        = op_ff;
      frame_in     = frame_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      taddr_in     = taddr_ff;
      tval_in      = tval_ff;
      fpb_in       = fpb_ff;
      bpb_in       = bpb_ff;
      alen_in      = alen_ff;
      nlen_in      = nlen_ff;
      last_beat_in = last_beat_ff;
      beat_seen_in = beat_seen_ff;
      playing_in   = playing_ff;
      play_acc_in  = play_acc_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      beat_in      = beat_ff;
      new_beat_in  = new_beat_ff;
      accent_in    = accent_ff;
      hit_in       = hit_ff;
      hit_acc_in   = hit_acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      // settings writes
      if (csr_we) begin
         unique case (csr_addr)
            mcg_pkg::CSR_FPB:  fpb_in  = csr_wdata;
            mcg_pkg::CSR_BPB:  bpb_in  = csr_wdata[mcg_pkg::BPB_W-1:0];
            mcg_pkg::CSR_ALEN: alen_in = csr_wdata[LW-1:0];
            mcg_pkg::CSR_NLEN: nlen_in = csr_wdata[LW-1:0];
            default:           ;
         endcase
      end

      // capture the request word
      if (accept) begin
         op_in       = mcg_pkg::opcode_type'(req_tuser);
         frame_in    = req_tdata[47:0];
         left_in     = req_tdata[63:48];
         right_in    = req_tdata[79:64];
         taddr_in    = req_tdata[91:80];
         tval_in     = req_tdata[107:92];
         new_beat_in = 1'b0;
         accent_in   = 1'b0;
         hit_in      = 1'b0;
      end

      // playback reset
      if (misc_go && op_ff == mcg_pkg::OP_RESET) begin
         playing_in   = 1'b0;
         play_acc_in  = 1'b0;
         pos_in       = '0;
         beat_seen_in = 1'b0;
         last_beat_in = '0;
      end

      // divider load and step
      if (div_load_num) begin
         dvd_in = num_mag;
         dsr_in = fpb_ff;
         rem_in = '0;
         cnt_in = CW'(NumW - 1);
      end
      if (div_load_beat) begin
         dvd_in = beat_mag;
         dsr_in = {{(FW - mcg_pkg::BPB_W){1'b0}}, bpb_eff};
         rem_in = '0;
         cnt_in = CW'(NumW - 1);
      end
      if (div_step) begin
         rem_in = ge ? diff[FW-1:0] : part[FW-1:0];
         dvd_in = {dvd_ff[NumW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end

      // floor quotient: a negative inexact quotient steps one further down
      if (state_ff == mcg_pkg::ST_BEAT) begin
         if (frame_ff[mcg_pkg::FRAME_W-1]) begin
            beat_in = (rem_ff != '0) ? ~dvd_ff : -dvd_ff;
         end else begin
            beat_in = dvd_ff;
         end
      end

      // new beat starts a click
      if (state_ff == mcg_pkg::ST_ACCENT) begin
         last_beat_in = beat_ff;
         beat_seen_in = 1'b1;
         playing_in   = 1'b1;
         play_acc_in  = (rem_ff == '0);
         pos_in       = '0;
         new_beat_in  = 1'b1;
         accent_in    = (rem_ff == '0);
      end

      // one click sample per frame
      if (play_step) begin
         hit_in     = pos_hit;
         hit_acc_in = play_acc_ff;
         pos_in     = pos_after;
         if (playing_ff && pos_after >= len_c) begin
            playing_in = 1'b0;
         end
      end

      // result word
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (op_ff == mcg_pkg::OP_FRAME) begin
            rsp_data_in[15:0]  = sat16(sum_l);
            rsp_data_in[31:16] = (mcg_pkg::CHANNELS >= 2) ? sat16(sum_r) : right_ff;
            rsp_data_in[47:32] = click;
         end else begin
            rsp_data_in[15:0]  = left_ff;
            rsp_data_in[31:16] = right_ff;
            rsp_data_in[47:32] = '0;
         end
         rsp_user_in = {accent_ff, new_beat_ff};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcg_pkg::ST_IDLE;
         fpb_ff       <= '0;
         bpb_ff       <= mcg_pkg::BPB_RESET;
         alen_ff      <= '0;
         nlen_ff      <= '0;
         last_beat_ff <= '0;
         beat_seen_ff <= 1'b0;
         playing_ff   <= 1'b0;
         play_acc_ff  <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fpb_ff       <= fpb_in;
         bpb_ff       <= bpb_in;
         alen_ff      <= alen_in;
         nlen_ff      <= nlen_in;
         last_beat_ff <= last_beat_in;
         beat_seen_ff <= beat_seen_in;
         playing_ff   <= playing_in;
         play_acc_ff  <= play_acc_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      frame_ff    <= frame_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      taddr_ff    <= taddr_in;
      tval_ff     <= tval_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      dvd_ff      <= dvd_in;
      cnt_ff      <= cnt_in;
      beat_ff     <= beat_in;
      new_beat_ff <= new_beat_in;
      accent_ff   <= accent_in;
      hit_ff      <= hit_in;
      hit_acc_ff  <= hit_acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // click tables
   mcg_ram #(
      .WIDTH (SW),
      .DEPTH (CLICK_DEPTH)
   ) u_accent_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (wr_addr),
      .wr_data (tval_ff),
      .rd_en   (play_step),
      .rd_addr (rd_addr),
      .rd_data (acc_rd)
   );

   mcg_ram #(
      .WIDTH (SW),
      .DEPTH (CLICK_DEPTH)
   ) u_normal_ram (
      .clock   (clock),
      .wr_en   (nrm_we),
      .wr_addr (wr_addr),
      .wr_data (tval_ff),
      .rd_en   (play_step),
      .rd_addr (rd_addr),
      .rd_data (nrm_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
